@@ rtl/imufps_pkg.sv @@
`default_nettype none

package imufps_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam int unsigned POS_W      = 4;
  localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
  localparam logic [POS_W-1:0] POS_PAY0  = 4'd2;
  localparam logic [POS_W-1:0] POS_PAY5  = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd9;
  localparam logic [POS_W-1:0] POS_CSUM  = 4'd10;

  localparam int unsigned AXIS_W     = 20;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned PAY_BYTES  = 6;

  localparam logic signed [15:0] PITCH_OFFSET_RST = 16'sd1408;

  // kind of frame held while parsing
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ANGLE = 2'd1,
    KIND_RATE  = 2'd2
  } kind_t;

  // output frame_kind codes
  localparam logic OUT_KIND_ANGLE = 1'b0;
  localparam logic OUT_KIND_RATE  = 1'b1;

  // one checked frame, raw words
  typedef struct packed {
    logic                    is_rate;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } frame_t;

endpackage

`default_nettype wire

@@ rtl/imufps_parser.sv @@
`default_nettype none

module imufps_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,
  output logic                      ev_valid,
  input  wire logic                 ev_ready,
  output imufps_pkg::frame_t        ev_frame
);
  import imufps_pkg::*;

  logic             in_frame_r, in_frame_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  kind_t            ftype_r, ftype_nxt;
  logic [7:0]       pay_r [PAY_BYTES];
  logic             ev_valid_r, ev_valid_nxt;
  frame_t           ev_r, ev_nxt;
  logic             accept;
  logic             pay_we;
  logic [2:0]       pay_idx;
  logic             emit;

  assign in_tready = !ev_valid_r || ev_ready;
  assign accept    = in_tvalid && in_tready;
  assign pay_idx   = 3'(pos_r - POS_PAY0);
  assign pay_we    = accept && in_frame_r && (pos_r >= POS_PAY0) && (pos_r <= POS_PAY5);

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    ftype_nxt    = ftype_r;
    emit         = 1'b0;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_tdata == HDR_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = POS_TYPE;
          sum_nxt      = HDR_BYTE;
        end
      end else if (pos_r >= POS_TYPE && pos_r <= POS_LAST) begin
        sum_nxt = sum_r + in_tdata;
        pos_nxt = pos_r + 4'd1;
        if (pos_r == POS_TYPE) begin
          if (in_tdata == TYPE_ANGLE) begin
            ftype_nxt = KIND_ANGLE;
          end else if (in_tdata == TYPE_RATE) begin
            ftype_nxt = KIND_RATE;
          end else begin
            ftype_nxt = KIND_NONE;
          end
        end
      end else begin
        // checksum byte or a stray position: frame ends either way
        emit         = (pos_r == POS_CSUM) && (sum_r == in_tdata) && (ftype_r != KIND_NONE);
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        sum_nxt      = '0;
        ftype_nxt    = KIND_NONE;
      end
    end
  end

  always_comb begin
    ev_nxt.is_rate = (ftype_r == KIND_RATE);
    ev_nxt.raw_x   = {pay_r[1], pay_r[0]};
    ev_nxt.raw_y   = {pay_r[3], pay_r[2]};
    ev_nxt.raw_z   = {pay_r[5], pay_r[4]};
    ev_valid_nxt   = ev_valid_r;
    if (ev_valid_r && ev_ready) begin
      ev_valid_nxt = 1'b0;
    end
    if (emit) begin
      ev_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
      ftype_r    <= KIND_NONE;
      ev_valid_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      ftype_r    <= ftype_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_r[pay_idx] <= in_tdata;
    end
    if (emit) begin
      ev_r <= ev_nxt;
    end
  end

  assign ev_valid = ev_valid_r;
  assign ev_frame = ev_r;

endmodule

`default_nettype wire

@@ rtl/imufps_scaler.sv @@
`default_nettype none

module imufps_scaler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [15:0]                   cfg_wdata,
  input  wire logic                          ev_valid,
  output logic                               ev_ready,
  input  wire imufps_pkg::frame_t            ev_frame,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic                               res_kind,
  output logic [3*imufps_pkg::AXIS_W-1:0]    res_axes
);
  import imufps_pkg::*;

  localparam logic signed [AXIS_W-1:0] WRAP_360 = 20'sd92160;

  logic signed [15:0]       pitch_off_r;
  logic                     res_valid_r;
  logic                     res_kind_r, res_kind_nxt;
  logic [3*AXIS_W-1:0]      res_axes_r, res_axes_nxt;
  logic signed [AXIS_W-1:0] x_val, y_val, z_val, y_ang;
  logic                     take;

  // raw*180/32768 deg, in 1/256 deg units = floor(raw*45/32)
  function automatic logic signed [AXIS_W-1:0] scale_angle(logic signed [RAW_W-1:0] r);
    logic signed [21:0] p;
    p = $signed({{6{r[RAW_W-1]}}, r}) * 22'sd45;
    return $signed({{3{p[21]}}, p[21:5]});
  endfunction

  // raw*2000/32768, in 1/256 units = floor(raw*125/8)
  function automatic logic signed [AXIS_W-1:0] scale_rate(logic signed [RAW_W-1:0] r);
    logic signed [23:0] p;
    p = $signed({{8{r[RAW_W-1]}}, r}) * 24'sd125;
    return $signed(p[22:3]);
  endfunction

  assign ev_ready = !res_valid_r || res_ready;
  assign take     = ev_valid && ev_ready;

  always_comb begin
    y_ang = scale_angle(ev_frame.raw_y);
    if (!ev_frame.raw_y[RAW_W-1] && ev_frame.raw_y[RAW_W-2]) begin
      y_ang = y_ang - WRAP_360;
    end
    y_ang = y_ang + AXIS_W'(pitch_off_r);
    if (ev_frame.is_rate) begin
      x_val        = scale_rate(ev_frame.raw_x);
      y_val        = scale_rate(ev_frame.raw_y);
      z_val        = scale_rate(ev_frame.raw_z);
      res_kind_nxt = OUT_KIND_RATE;
    end else begin
      x_val        = scale_angle(ev_frame.raw_x);
      y_val        = y_ang;
      z_val        = scale_angle(ev_frame.raw_z);
      res_kind_nxt = OUT_KIND_ANGLE;
    end
    res_axes_nxt = {z_val, y_val, x_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_off_r <= PITCH_OFFSET_RST;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pitch_off_r <= cfg_wdata;
      end
      if (take) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_kind_r <= res_kind_nxt;
      res_axes_r <= res_axes_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_kind  = res_kind_r;
  assign res_axes  = res_axes_r;

endmodule

`default_nettype wire

@@ rtl/imu_frame_parser_scaler_unit.sv @@
// result path: checksum byte -> parser event register -> result register -> out_tvalid
// throughput: one byte per cycle while in_tready is high, one result per good 11-byte frame
// the byte step is set by the parser register; scaling sits in the result register stage
// reset (rst_n low, synchronous): parser idle waiting for header, no result pending,
// pitch_offset back to 1408 (5.5 deg)
`default_nettype none

module imu_frame_parser_scaler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // pitch_offset
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,   // axis_x [19:0], axis_y [39:20], axis_z [59:40], zeros
  output logic [0:0]       out_tuser    // frame_kind
);
  import imufps_pkg::*;

  logic                res_kind;
  logic [3*AXIS_W-1:0] res_axes;
  logic                ev_valid;
  logic                ev_ready;
  frame_t              ev_frame;

  imufps_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev_frame  (ev_frame)
  );

  imufps_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev_frame  (ev_frame),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (res_kind),
    .res_axes  (res_axes)
  );

  assign out_tdata = {{(64 - 3*AXIS_W){1'b0}}, res_axes};
  assign out_tuser = res_kind;

endmodule

`default_nettype wire

@@ rtl/imufps_checker.sv @@
`default_nettype none

module imufps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a new result follows an accepted byte, through the parser event and result registers
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a checksum byte");

  // input stalls only when the output is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind imu_frame_parser_scaler_unit imufps_checker u_imufps_checker (.*);

`default_nettype wire
